/* sv/cslc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centrifuge line clear sequencer package
// Shared types, operation and register codes, field positions and constants.
// ----------------------------------------------------------------------------
package cslc_pkg;

    // Operation selector carried on the input tuser.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ALARM = 2'd1;
    localparam logic [1:0] OP_ARM   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INLET_FLOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_VOLUME_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_HALF_VOLUME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAG_LINE_VOLUME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_FLOW_CAP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPIN_DOWN_RPM      = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_MIN_INLET_FLOW     = 16'd320;
    localparam logic [15:0] RST_CLEAR_VOLUME_LIMIT = 16'd1120;
    localparam logic [15:0] RST_CLEAR_HALF_VOLUME  = 16'd560;
    localparam logic [15:0] RST_BAG_LINE_VOLUME    = 16'd800;
    localparam logic [15:0] RST_RETURN_FLOW_CAP    = 16'd1760;
    localparam logic [12:0] RST_SPIN_DOWN_RPM      = 13'd1850;

    // Centrifuge speed commands.
    localparam logic [12:0] RPM_SLOW = 13'd1800;
    localparam logic [12:0] RPM_FAST = 13'd3000;

    // Recovery phase codes.
    localparam logic [2:0] PHASE_SPIN_DOWN    = 3'd0;
    localparam logic [2:0] PHASE_CLEAR_FIRST  = 3'd1;
    localparam logic [2:0] PHASE_CLEAR_SECOND = 3'd2;
    localparam logic [2:0] PHASE_BAG_LINE     = 3'd3;
    localparam logic [2:0] PHASE_DONE         = 3'd4;

    // Flow command slots and valve slots.
    localparam int F_PLASMA  = 0;
    localparam int F_AC      = 1;
    localparam int F_COLLECT = 2;
    localparam int F_INLET   = 3;
    localparam int F_RETURN  = 4;
    localparam int NUM_FLOWS = 5;
    localparam int V_COLLECT = 0;
    localparam int V_RBC     = 1;
    localparam int V_PLASMA  = 2;

    // Divider: 32-bit quotient, two quotient bits per cycle.
    localparam int QUOT_W        = 32;
    localparam int DIV_BITS      = 2;
    localparam int DIV_CYCLES    = QUOT_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    // Stream widths.
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 104;
    localparam int OUT_PHASE_LSB = 97;

    // One input item.
    typedef struct packed {
        logic [1:0]        operation;
        logic [15:0]       pred_return_flow;
        logic [15:0]       pred_inlet_flow;
        logic [15:0]       pred_collect_flow;
        logic [15:0]       pred_plasma_flow;
        logic [15:0]       pred_ac_flow;
        logic signed [12:0] inlet_volume_step;
        logic [12:0]       centrifuge_rpm;
        logic              draw_cycle;
        logic              alarm_active;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        collect_valve;
        logic        rbc_valve;
        logic        plasma_valve;
        logic [12:0] rpm_command;
        logic [15:0] plasma_flow_cmd;
        logic [15:0] ac_flow_cmd;
        logic [15:0] collect_flow_cmd;
        logic [15:0] inlet_flow_cmd;
        logic [15:0] return_flow_cmd;
        logic        recovery_active;
        logic [2:0]  phase;
    } result_t;

    // Commands from the controller.
    typedef struct packed {
        logic ready;
        logic capture;
        logic div_init;
        logic div_step;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    // Status towards the controller.
    typedef struct packed {
        logic in_valid;
        logic need_div;
        logic out_free;
    } ctrl_status_t;

endpackage

/* sv/cslc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centrifuge line clear sequencer controller
// Steps one item through capture, evaluation, optional division, state
// commit and hand-over to the output register.
// ----------------------------------------------------------------------------
module cslc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cslc_pkg::ctrl_status_t status,
    output cslc_pkg::ctrl_cmd_t    cmd
);
    import cslc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = status.in_valid;
                if (status.in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = status.need_div ? ST_DIV : ST_COMMIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/cslc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centrifuge line clear sequencer datapath
// Configuration registers, sequence state, held commands, the ratio
// multiplier and a radix-4 restoring divider.
// ----------------------------------------------------------------------------
module cslc_dp
#(
    parameter int FLOW_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cslc_pkg::ctrl_cmd_t                 cmd,
    input  cslc_pkg::in_item_t                  in_item,
    input  logic                                cfg_valid,
    input  logic [cslc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data,
    output logic                                need_div,
    output cslc_pkg::result_t                   result
);
    import cslc_pkg::*;

    localparam logic [32:0] FLOW_MAX = (33'd1 << FLOW_WIDTH) - 33'd1;

    // Saturate a 16-bit flow to the flow range, result kept on 16 bits.
    function automatic logic [15:0] sat16(input logic [15:0] v);
        sat16 = ({17'd0, v} > FLOW_MAX) ? FLOW_MAX[15:0] : v;
    endfunction

    // Saturate the quotient to the flow range.
    function automatic logic [FLOW_WIDTH-1:0] sat_quot(input logic [QUOT_W-1:0] v);
        logic [32:0] t;
        t = ({1'b0, v} > FLOW_MAX) ? FLOW_MAX : {1'b0, v};
        sat_quot = t[FLOW_WIDTH-1:0];
    endfunction

    // Widen or narrow an in-range 16-bit value to the flow width.
    function automatic logic [FLOW_WIDTH-1:0] to_flow(input logic [15:0] v);
        logic [FLOW_WIDTH+15:0] t;
        t = {{FLOW_WIDTH{1'b0}}, v};
        to_flow = t[FLOW_WIDTH-1:0];
    endfunction

    // Low 16 bits of a flow command.
    function automatic logic [15:0] to16(input logic [FLOW_WIDTH-1:0] v);
        logic [FLOW_WIDTH+15:0] t;
        t = {16'd0, v};
        to16 = t[15:0];
    endfunction

    // Volume accumulator add, saturating at 0 and 65535.
    function automatic logic [15:0] acc_add(input logic [15:0] acc,
                                            input logic [12:0] step);
        logic signed [17:0] sum;
        sum = $signed({2'b00, acc}) + $signed({{5{step[12]}}, step});
        if (sum < 0)
            acc_add = 16'd0;
        else if (sum > 18'sd65535)
            acc_add = 16'hFFFF;
        else
            acc_add = sum[15:0];
    endfunction

    // Configuration registers.
    logic [15:0] min_inlet_reg, clear_limit_reg, clear_half_reg;
    logic [15:0] bag_limit_reg, return_cap_reg;
    logic [12:0] spin_rpm_reg;

    // Sequence state and held commands.
    logic                  at_alt_reg, listen_reg, req_reg;
    logic [15:0]           clear_vol_reg, bag_vol_reg;
    logic [2:0]            valve_reg;
    logic [FLOW_WIDTH-1:0] flow_reg [NUM_FLOWS];
    logic [12:0]           speed_reg;

    logic                  at_alt_next, listen_next, req_next;
    logic [15:0]           clear_vol_next, bag_vol_next;
    logic [2:0]            valve_next;
    logic [FLOW_WIDTH-1:0] flow_next [NUM_FLOWS];
    logic [12:0]           speed_next;

    // Captured item and divider registers.
    in_item_t              item_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [15:0]           rem_reg;

    logic [15:0] qret, qin, qc, qp, qac;
    logic [15:0] clear_sum, bag_sum;
    logic        tick_run, floor_hit, use_div;
    logic [15:0] ac_half, in_half;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_inlet_reg   <= RST_MIN_INLET_FLOW;
            clear_limit_reg <= RST_CLEAR_VOLUME_LIMIT;
            clear_half_reg  <= RST_CLEAR_HALF_VOLUME;
            bag_limit_reg   <= RST_BAG_LINE_VOLUME;
            return_cap_reg  <= RST_RETURN_FLOW_CAP;
            spin_rpm_reg    <= RST_SPIN_DOWN_RPM;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_INLET_FLOW:     min_inlet_reg   <= cfg_data;
                CFG_CLEAR_VOLUME_LIMIT: clear_limit_reg <= cfg_data;
                CFG_CLEAR_HALF_VOLUME:  clear_half_reg  <= cfg_data;
                CFG_BAG_LINE_VOLUME:    bag_limit_reg   <= cfg_data;
                CFG_RETURN_FLOW_CAP:    return_cap_reg  <= cfg_data;
                CFG_SPIN_DOWN_RPM:      spin_rpm_reg    <= cfg_data[12:0];
                default:                ;
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // Saturated predicted flows and the capped return flow.
    always_comb
    begin
        logic [15:0] qrp;
        qrp  = sat16(item_reg.pred_return_flow);
        qin  = sat16(item_reg.pred_inlet_flow);
        qc   = sat16(item_reg.pred_collect_flow);
        qp   = sat16(item_reg.pred_plasma_flow);
        qac  = sat16(item_reg.pred_ac_flow);
        qret = (qrp > return_cap_reg) ? return_cap_reg : qrp;
    end

    assign clear_sum = acc_add(clear_vol_reg, item_reg.inlet_volume_step);
    assign bag_sum   = acc_add(bag_vol_reg, item_reg.inlet_volume_step);
    assign tick_run  = (item_reg.operation == OP_TICK) && req_reg && !item_reg.alarm_active;
    assign floor_hit = item_reg.draw_cycle && ({1'b0, qin[15:1]} <= min_inlet_reg)
                       && (qin != 16'd0);
    assign use_div   = floor_hit && (min_inlet_reg != 16'd0);
    assign ac_half   = {1'b0, qac[15:1]};
    assign in_half   = {1'b0, qin[15:1]};

    // Next sequence state for the captured item.
    always_comb
    begin
        at_alt_next    = at_alt_reg;
        listen_next    = listen_reg;
        req_next       = req_reg;
        clear_vol_next = clear_vol_reg;
        bag_vol_next   = bag_vol_reg;
        valve_next     = valve_reg;
        speed_next     = speed_reg;
        need_div       = 1'b0;
        for (int i = 0; i < NUM_FLOWS; i++)
        begin
            flow_next[i] = flow_reg[i];
        end

        case (item_reg.operation)
            OP_TICK:
            begin
                if (tick_run)
                begin
                    if (!at_alt_reg)
                    begin
                        // Spin down with all pumps stopped.
                        valve_next[V_RBC] = 1'b0;
                        speed_next        = RPM_SLOW;
                        for (int i = 0; i < NUM_FLOWS; i++)
                        begin
                            flow_next[i] = '0;
                        end
                        if (item_reg.centrifuge_rpm < spin_rpm_reg)
                        begin
                            at_alt_next = 1'b1;
                        end
                    end
                    else if (clear_vol_reg < clear_limit_reg)
                    begin
                        // Line clear; the half is chosen on the updated volume.
                        clear_vol_next      = clear_sum;
                        valve_next          = 3'b000;
                        flow_next[F_PLASMA] = '0;
                        flow_next[F_RETURN] = to_flow(qret);
                        if (clear_sum > clear_half_reg)
                        begin
                            flow_next[F_AC]      = to_flow(qac);
                            flow_next[F_COLLECT] = to_flow(qc);
                            flow_next[F_INLET]   = to_flow(qin);
                            speed_next           = RPM_FAST;
                        end
                        else
                        begin
                            flow_next[F_COLLECT] = to_flow({1'b0, qc[15:1]});
                            speed_next           = RPM_SLOW;
                            if (!item_reg.draw_cycle)
                            begin
                                flow_next[F_INLET] = '0;
                                flow_next[F_AC]    = '0;
                            end
                            else if (floor_hit)
                            begin
                                flow_next[F_INLET] = to_flow(sat16(min_inlet_reg));
                                flow_next[F_AC]    = use_div ? sat_quot(quot_reg)
                                                             : to_flow(ac_half);
                                need_div           = use_div;
                            end
                            else
                            begin
                                flow_next[F_INLET] = to_flow(in_half);
                                flow_next[F_AC]    = to_flow(ac_half);
                            end
                        end
                    end
                    else if (bag_vol_reg < bag_limit_reg)
                    begin
                        // Bag-line clear; alarm events now end recovery.
                        listen_next          = 1'b1;
                        bag_vol_next         = bag_sum;
                        valve_next[V_COLLECT] = 1'b0;
                        valve_next[V_RBC]     = 1'b1;
                        valve_next[V_PLASMA]  = 1'b0;
                        speed_next           = RPM_FAST;
                        flow_next[F_PLASMA]  = to_flow({1'b0, qp[15:1]});
                        flow_next[F_COLLECT] = to_flow({1'b0, qc[15:1]});
                        flow_next[F_RETURN]  = to_flow(qret);
                        if (!item_reg.draw_cycle)
                        begin
                            flow_next[F_INLET] = '0;
                            flow_next[F_AC]    = '0;
                        end
                        else if (floor_hit)
                        begin
                            flow_next[F_INLET] = to_flow(sat16(min_inlet_reg));
                            flow_next[F_AC]    = use_div ? sat_quot(quot_reg)
                                                         : to_flow(ac_half);
                            need_div           = use_div;
                        end
                        else
                        begin
                            flow_next[F_INLET] = to_flow(in_half);
                            flow_next[F_AC]    = to_flow(ac_half);
                        end
                    end
                    else
                    begin
                        req_next = 1'b0;
                    end
                end
            end
            OP_ALARM:
            begin
                if (listen_reg)
                begin
                    req_next = 1'b0;
                end
            end
            OP_ARM:
            begin
                req_next       = 1'b1;
                at_alt_next    = 1'b0;
                clear_vol_next = '0;
                bag_vol_next   = '0;
                listen_next    = 1'b0;
            end
            default:
            begin
                req_next = req_reg;
            end
        endcase
    end

    // Ratio multiply into the dividend, then two restoring steps per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quot_reg <= {16'd0, min_inlet_reg} * {16'd0, qac};
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            logic [QUOT_W-1:0] q;
            logic [15:0]       r;
            logic [16:0]       trial;
            q = quot_reg;
            r = rem_reg;
            for (int k = 0; k < DIV_BITS; k++)
            begin
                trial = {r, q[QUOT_W-1]};
                q     = {q[QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, qin})
                begin
                    trial = trial - {1'b0, qin};
                    q[0]  = 1'b1;
                end
                r = trial[15:0];
            end
            quot_reg <= q;
            rem_reg  <= r;
        end
    end

    // Sequence state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_alt_reg    <= 1'b0;
            listen_reg    <= 1'b0;
            req_reg       <= 1'b0;
            clear_vol_reg <= '0;
            bag_vol_reg   <= '0;
            valve_reg     <= '0;
            speed_reg     <= '0;
            for (int i = 0; i < NUM_FLOWS; i++)
            begin
                flow_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            at_alt_reg    <= at_alt_next;
            listen_reg    <= listen_next;
            req_reg       <= req_next;
            clear_vol_reg <= clear_vol_next;
            bag_vol_reg   <= bag_vol_next;
            valve_reg     <= valve_next;
            speed_reg     <= speed_next;
            for (int i = 0; i < NUM_FLOWS; i++)
            begin
                flow_reg[i] <= flow_next[i];
            end
        end
    end

    // Result from the committed state.
    always_comb
    begin
        result.collect_valve    = valve_reg[V_COLLECT];
        result.rbc_valve        = valve_reg[V_RBC];
        result.plasma_valve     = valve_reg[V_PLASMA];
        result.rpm_command      = speed_reg;
        result.plasma_flow_cmd  = to16(flow_reg[F_PLASMA]);
        result.ac_flow_cmd      = to16(flow_reg[F_AC]);
        result.collect_flow_cmd = to16(flow_reg[F_COLLECT]);
        result.inlet_flow_cmd   = to16(flow_reg[F_INLET]);
        result.return_flow_cmd  = to16(flow_reg[F_RETURN]);
        result.recovery_active  = req_reg && !item_reg.alarm_active;
        if (!at_alt_reg)
            result.phase = PHASE_SPIN_DOWN;
        else if (clear_vol_reg < clear_limit_reg)
            result.phase = (clear_vol_reg > clear_half_reg) ? PHASE_CLEAR_SECOND
                                                            : PHASE_CLEAR_FIRST;
        else if (bag_vol_reg < bag_limit_reg)
            result.phase = PHASE_BAG_LINE;
        else
            result.phase = PHASE_DONE;
    end

endmodule

/* sv/centrifuge_line_clear_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centrifuge line clear sequencer
// Recovery sequencer for spin-down, line clear and bag-line clear, driving
// valve, centrifuge speed and pump flow commands once per control tick.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Each item steps through capture,
// evaluation, commit and hand-over to the output register. When a draw-cycle
// tick hits the inlet flow floor, the anticoagulant command is rescaled
// before commit by a restoring divider that produces two of its 32 quotient
// bits per cycle. The next item is taken once the previous result sits in
// the output register, even while that result still waits to be transferred.
// Configuration writes are always taken and must be made only while no item
// is in progress.
module centrifuge_line_clear_sequencer
#(
    parameter int FLOW_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pred_return_flow[15:0], pred_inlet_flow[31:16], pred_collect_flow[47:32],
    // pred_plasma_flow[63:48], pred_ac_flow[79:64], inlet_volume_step[92:80],
    // centrifuge_rpm[105:93], draw_cycle[106], alarm_active[107], zero pad.
    input  logic [cslc_pkg::S_TDATA_W-1:0]       s_tdata,
    // operation[1:0].
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // collect_valve[0], rbc_valve[1], plasma_valve[2], rpm_command[15:3],
    // plasma_flow_cmd[31:16], ac_flow_cmd[47:32], collect_flow_cmd[63:48],
    // inlet_flow_cmd[79:64], return_flow_cmd[95:80], recovery_active[96],
    // phase[99:97], zero pad.
    output logic [cslc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cslc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);
    import cslc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    in_item_t     in_item;
    result_t      result;
    logic         need_div;

    result_t      out_reg;
    logic         out_valid_reg;

    // Unpack the input transfer.
    always_comb
    begin
        in_item.operation         = s_tuser;
        in_item.pred_return_flow  = s_tdata[15:0];
        in_item.pred_inlet_flow   = s_tdata[31:16];
        in_item.pred_collect_flow = s_tdata[47:32];
        in_item.pred_plasma_flow  = s_tdata[63:48];
        in_item.pred_ac_flow      = s_tdata[79:64];
        in_item.inlet_volume_step = s_tdata[92:80];
        in_item.centrifuge_rpm    = s_tdata[105:93];
        in_item.draw_cycle        = s_tdata[106];
        in_item.alarm_active      = s_tdata[107];
    end

    assign status.in_valid = s_tvalid;
    assign status.need_div = need_div;
    assign status.out_free = !out_valid_reg || m_tready;
    assign s_tready        = cmd.ready;
    assign cfg_ready       = 1'b1;

    cslc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    cslc_dp
    #(
        .FLOW_WIDTH (FLOW_WIDTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .need_div  (need_div),
        .result    (result)
    );

    // Output register: holds a finished result until it is transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= result;
        end
    end

    // Pack the output transfer.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.phase, out_reg.recovery_active,
                       out_reg.return_flow_cmd, out_reg.inlet_flow_cmd,
                       out_reg.collect_flow_cmd, out_reg.ac_flow_cmd,
                       out_reg.plasma_flow_cmd, out_reg.rpm_command,
                       out_reg.plasma_valve, out_reg.rbc_valve, out_reg.collect_valve};

    // Only one item is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // A result appears only at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result presented without an item in progress");

    // The reported phase is always a defined phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_PHASE_LSB +: 3] <= PHASE_DONE))
        else $error("phase out of range");

endmodule
